### hw/rtl/spte_pkg.sv
// Shared types and constants of the spline point and tangent evaluator.
package spte_pkg;

  // Opcode of an input request
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } spte_op_t;

  // Register index on the configuration port (byte address / 4)
  typedef enum logic {
    REG_CURVE_KIND  = 1'b0,
    REG_POINT_COUNT = 1'b1
  } spte_reg_t;

  localparam int ADDR_W = 3;

  // Raw derivative width after rounding to Q16.16 (unsaturated)
  localparam int RAW_W = 38;
  localparam int POS_W = 6;

  // Width of the exact basis polynomial terms
  localparam int PQ_W = 56;

  // Cycles from the accepting edge of an evaluate to the edge that takes its result
  localparam int LATENCY = 64;

  typedef struct packed {
    spte_op_t           opcode;
    logic [5:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [16:0]        param_t;
  } spte_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic               dir_normalized;
  } spte_out_t;

  // Position and raw derivative handed to the normalizer
  typedef struct packed {
    logic                  valid;
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
    logic signed [RAW_W-1:0] rx;
    logic signed [RAW_W-1:0] ry;
  } spte_deriv_t;

endpackage

### hw/rtl/spline_point_and_tangent_eval.sv
// Top level: control point table, basis weights, dot products and config port.
//
// Takes one request per clock: busy stays low, so every request with start high is
// accepted, and each evaluate request gives its result on out_res, marked by out_valid
// for one cycle, at the end of the pipeline; loads give no result. Most of the pipeline
// depth is the 32-stage square root and the 17-stage divider of the tangent normalizer.
// The point table sits in two copies of a synchronous RAM with two read ports each,
// so all four stencil points are read in the accepting cycle; a load is written at
// its accepting edge and is seen by the very next evaluate. Slots never loaded read
// as undefined. Results cannot be held off.
module spline_point_and_tangent_eval #(
  parameter int MAX_POINTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  spte_pkg::spte_in_t          in_req,
  // result channel
  output logic                        out_valid,
  output spte_pkg::spte_out_t         out_res,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spte_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = ($clog2(MAX_POINTS + 1) > 7) ? $clog2(MAX_POINTS + 1) : 7;
  localparam int SW = NW + 17;
  localparam int PW = spte_pkg::PQ_W;

  localparam logic signed [PW-1:0] ONE32 = PW'(64'sd1 <<< 32);
  localparam logic signed [PW-1:0] ONE48 = PW'(64'sd1 <<< 48);
  localparam logic signed [PW-1:0] HALF_B = PW'(64'sd3 <<< 20);
  localparam logic signed [PW-1:0] HALF_C = PW'(64'sd1 <<< 20);
  localparam logic signed [PW-1:0] HALF_D = PW'(64'sd16);
  localparam logic [31:0]          RECIP3 = 32'hAAAAAAAB;

  // Configuration registers
  logic       curve_kind_r;
  logic [6:0] point_count_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_kind_r  <= 1'b0;
      point_count_r <= 7'd4;
    end else if (cfg_wr) begin
      case (spte_pkg::spte_reg_t'(paddr[2]))
        spte_pkg::REG_CURVE_KIND:  curve_kind_r  <= pwdata[0];
        spte_pkg::REG_POINT_COUNT: point_count_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (spte_pkg::spte_reg_t'(paddr[2]))
      spte_pkg::REG_CURVE_KIND:  prdata = {31'd0, curve_kind_r};
      spte_pkg::REG_POINT_COUNT: prdata = {25'd0, point_count_r};
      default:                   prdata = '0;
    endcase
  end

  // Request decode
  logic acc, acc_eval, acc_load;
  assign acc      = start && !busy;
  assign acc_eval = acc && (in_req.opcode == spte_pkg::OP_EVAL);
  assign acc_load = acc && (in_req.opcode == spte_pkg::OP_LOAD);

  // Segment, local parameter and stencil addresses
  logic [NW-1:0] n, pc, segs, seg, i0, i1, i2, i3, slot;
  logic [16:0]   t_sat;
  logic [SW-1:0] scaled, u_full;
  logic          wr_en;

  always_comb begin
    pc = NW'(point_count_r);
    if (pc < NW'(4))                n = NW'(4);
    else if (pc > NW'(MAX_POINTS))  n = NW'(MAX_POINTS);
    else                            n = pc;
    t_sat  = (in_req.param_t > 17'd65536) ? 17'd65536 : in_req.param_t;
    segs   = curve_kind_r ? n - NW'(1) : n - NW'(3);
    scaled = SW'(t_sat) * SW'(segs);
    seg    = NW'(scaled >> 16);
    if (seg >= segs) seg = segs - NW'(1);
    u_full = scaled - (SW'(seg) << 16);
    if (curve_kind_r) begin
      i0 = (seg > NW'(0)) ? seg - NW'(1) : NW'(0);
      i1 = seg;
      i2 = seg + NW'(1);
      i3 = (seg + NW'(2) < n) ? seg + NW'(2) : n - NW'(1);
    end else begin
      i0 = seg;
      i1 = seg + NW'(1);
      i2 = seg + NW'(2);
      i3 = seg + NW'(3);
    end
    slot  = NW'(in_req.point_index);
    wr_en = acc_load && (slot < NW'(MAX_POINTS));
  end

  // Point table: two copies, each with two read ports
  logic [63:0] mem_a [0:MAX_POINTS-1];
  logic [63:0] mem_b [0:MAX_POINTS-1];
  logic [3:0][63:0] pts1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[slot[AW-1:0]] <= {in_req.point_x, in_req.point_y};
      mem_b[slot[AW-1:0]] <= {in_req.point_x, in_req.point_y};
    end
    pts1_r[0] <= mem_a[i0[AW-1:0]];
    pts1_r[1] <= mem_a[i1[AW-1:0]];
    pts1_r[2] <= mem_b[i2[AW-1:0]];
    pts1_r[3] <= mem_b[i3[AW-1:0]];
  end

  // Stage 1 control
  logic        v1_r, cr1_r;
  logic [16:0] u1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc_eval;
    end
    cr1_r <= curve_kind_r;
    u1_r  <= u_full[16:0];
  end

  // Stage 2: u^2
  logic             v2_r, cr2_r;
  logic [16:0]      u2a_r;
  logic [33:0]      u2_r;
  logic [3:0][63:0] pts2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    cr2_r  <= cr1_r;
    u2a_r  <= u1_r;
    u2_r   <= 34'(u1_r) * 34'(u1_r);
    pts2_r <= pts1_r;
  end

  // Stage 3: u^3
  logic             v3_r, cr3_r;
  logic [16:0]      u3a_r;
  logic [33:0]      u3b_r;
  logic [50:0]      u3_r;
  logic [3:0][63:0] pts3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    cr3_r  <= cr2_r;
    u3a_r  <= u2a_r;
    u3b_r  <= u2_r;
    u3_r   <= 51'(u2_r) * 51'(u2a_r);
    pts3_r <= pts2_r;
  end

  // Stage 4: exact basis polynomials, rounded toward the weight scale
  logic signed [PW-1:0] su, su2, su3;
  logic signed [PW-1:0] p [4];
  logic signed [PW-1:0] q [4];
  logic signed [PW-1:0] pb [4];
  logic signed [PW-1:0] pc_sh [4];
  logic signed [PW-1:0] qd_sh [4];

  always_comb begin
    su  = PW'(u3a_r);
    su2 = PW'(u3b_r);
    su3 = PW'(u3_r);
    if (!cr3_r) begin
      p[0] = ONE48 - 3 * (su <<< 32) + 3 * (su2 <<< 16) - su3;
      p[1] = 3 * su3 - 6 * (su2 <<< 16) + 4 * ONE48;
      p[2] = -3 * su3 + 3 * (su2 <<< 16) + 3 * (su <<< 32) + ONE48;
      p[3] = su3;
      q[0] = -(ONE32 - 2 * (su <<< 16) + su2);
      q[1] = 3 * su2 - 4 * (su <<< 16);
      q[2] = -3 * su2 + 2 * (su <<< 16) + ONE32;
      q[3] = su2;
    end else begin
      p[0] = -su3 + 2 * (su2 <<< 16) - (su <<< 32);
      p[1] = 3 * su3 - 5 * (su2 <<< 16) + 2 * ONE48;
      p[2] = -3 * su3 + 4 * (su2 <<< 16) + (su <<< 32);
      p[3] = su3 - (su2 <<< 16);
      q[0] = -3 * su2 + 4 * (su <<< 16) - ONE32;
      q[1] = 9 * su2 - 10 * (su <<< 16);
      q[2] = -9 * su2 + 8 * (su <<< 16) + ONE32;
      q[3] = 3 * su2 - 2 * (su <<< 16);
    end
    for (int i = 0; i < 4; i++) begin
      pb[i]    = (p[i] + HALF_B) >>> 21;
      pc_sh[i] = (p[i] + HALF_C) >>> 21;
      qd_sh[i] = (q[i] + HALF_D) >>> 5;
    end
  end

  logic                    v4_r, cr4_r;
  logic [3:0][31:0]        y4_r;
  logic [3:0][31:0]        wc4_r;
  logic [3:0][31:0]        d4_r;
  logic [3:0][63:0]        pts4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    cr4_r  <= cr3_r;
    pts4_r <= pts3_r;
    for (int i = 0; i < 4; i++) begin
      y4_r[i]  <= pb[i][31:0];
      wc4_r[i] <= pc_sh[i][31:0];
      d4_r[i]  <= qd_sh[i][31:0];
    end
  end

  // Stage 5: B-spline weights divided by three through the reciprocal, other weights passed on
  logic [63:0]      r3 [4];
  logic             v5_r;
  logic [3:0][31:0] w5_r;
  logic [3:0][31:0] d5_r;
  logic [3:0][63:0] pts5_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r3[i] = 64'(y4_r[i]) * 64'(RECIP3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    d5_r   <= d4_r;
    pts5_r <= pts4_r;
    for (int i = 0; i < 4; i++) begin
      w5_r[i] <= cr4_r ? wc4_r[i] : {1'b0, r3[i][63:33]};
    end
  end

  // Stage 6: weight times point products
  logic                     v6_r;
  logic signed [63:0]       pax_r [4];
  logic signed [63:0]       pay_r [4];
  logic signed [63:0]       ptx_r [4];
  logic signed [63:0]       pty_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    for (int i = 0; i < 4; i++) begin
      pax_r[i] <= $signed(w5_r[i]) * $signed(pts5_r[i][63:32]);
      pay_r[i] <= $signed(w5_r[i]) * $signed(pts5_r[i][31:0]);
      ptx_r[i] <= $signed(d5_r[i]) * $signed(pts5_r[i][63:32]);
      pty_r[i] <= $signed(d5_r[i]) * $signed(pts5_r[i][31:0]);
    end
  end

  // Stage 7: pairwise sums
  logic               v7_r;
  logic signed [64:0] sax_r [2];
  logic signed [64:0] say_r [2];
  logic signed [64:0] stx_r [2];
  logic signed [64:0] sty_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    for (int k = 0; k < 2; k++) begin
      sax_r[k] <= 65'(pax_r[2*k]) + 65'(pax_r[2*k+1]);
      say_r[k] <= 65'(pay_r[2*k]) + 65'(pay_r[2*k+1]);
      stx_r[k] <= 65'(ptx_r[2*k]) + 65'(ptx_r[2*k+1]);
      sty_r[k] <= 65'(pty_r[2*k]) + 65'(pty_r[2*k+1]);
    end
  end

  // Stage 8: final sums, rounding to Q16.16, position saturation
  localparam logic signed [65:0] RND = 66'sd1 <<< 27;
  localparam int RW = spte_pkg::RAW_W;

  logic signed [65:0]   tax, tay, ttx, tty;
  logic signed [RW-1:0] rax, ray;
  logic signed [31:0]   spx, spy;
  spte_pkg::spte_deriv_t deriv_r;

  function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] v);
    logic signed [31:0] r;
    if (v > RW'(64'sd2147483647))       r = 32'sh7FFFFFFF;
    else if (v < RW'(-64'sd2147483648)) r = 32'sh80000000;
    else                                r = v[31:0];
    return r;
  endfunction

  always_comb begin
    tax = (66'(sax_r[0]) + 66'(sax_r[1]) + RND) >>> 28;
    tay = (66'(say_r[0]) + 66'(say_r[1]) + RND) >>> 28;
    ttx = (66'(stx_r[0]) + 66'(stx_r[1]) + RND) >>> 28;
    tty = (66'(sty_r[0]) + 66'(sty_r[1]) + RND) >>> 28;
    rax = tax[RW-1:0];
    ray = tay[RW-1:0];
    spx = sat32(rax);
    spy = sat32(ray);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deriv_r.valid <= 1'b0;
    end else begin
      deriv_r.valid <= v7_r;
    end
    deriv_r.pos_x <= spx;
    deriv_r.pos_y <= spy;
    deriv_r.rx    <= ttx[RW-1:0];
    deriv_r.ry    <= tty[RW-1:0];
  end

  // Tangent normalization and output register
  spte_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .deriv     (deriv_r),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

### hw/rtl/spte_norm.sv
// Tangent normalizer: magnitude scaling, pipelined square root and divides.
module spte_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spte_pkg::spte_deriv_t deriv,
  output logic                 out_valid,
  output spte_pkg::spte_out_t  out_res
);

  localparam int RW     = spte_pkg::RAW_W;
  localparam int SQ_N   = 32;
  localparam int DV_N   = 17;
  localparam int NUM_W  = 49;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               neg_x;
    logic               neg_y;
    logic               nz;
  } side_t;

  // Stage 1: magnitudes, signs and zero test
  logic          n1_v_r;
  side_t         n1_side_r;
  logic [RW-1:0] n1_mx_r, n1_my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_v_r <= 1'b0;
    end else begin
      n1_v_r <= deriv.valid;
    end
    n1_side_r.pos_x <= deriv.pos_x;
    n1_side_r.pos_y <= deriv.pos_y;
    n1_side_r.neg_x <= deriv.rx[RW-1];
    n1_side_r.neg_y <= deriv.ry[RW-1];
    n1_side_r.nz    <= (deriv.rx != '0) || (deriv.ry != '0);
    n1_mx_r <= deriv.rx[RW-1] ? RW'(-deriv.rx) : RW'(deriv.rx);
    n1_my_r <= deriv.ry[RW-1] ? RW'(-deriv.ry) : RW'(deriv.ry);
  end

  // Stage 2: top set bit of the larger magnitude
  logic [RW-1:0]                  n1_m;
  logic [spte_pkg::POS_W-1:0]     n1_pos;
  logic                           n2_v_r;
  side_t                          n2_side_r;
  logic [RW-1:0]                  n2_mx_r, n2_my_r;
  logic [spte_pkg::POS_W-1:0]     n2_pos_r;

  always_comb begin
    n1_m   = (n1_mx_r > n1_my_r) ? n1_mx_r : n1_my_r;
    n1_pos = '0;
    for (int i = 0; i < RW; i++) begin
      if (n1_m[i]) n1_pos = spte_pkg::POS_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n2_v_r <= 1'b0;
    end else begin
      n2_v_r <= n1_v_r;
    end
    n2_side_r <= n1_side_r;
    n2_mx_r   <= n1_mx_r;
    n2_my_r   <= n1_my_r;
    n2_pos_r  <= n1_pos;
  end

  // Stage 3: shift both components so the larger sits in [2^30, 2^31)
  logic [RW-1:0] n2_sx, n2_sy;
  logic          n3_v_r;
  side_t         n3_side_r;
  logic [30:0]   n3_nx_r, n3_ny_r;

  always_comb begin
    if (n2_pos_r >= spte_pkg::POS_W'(30)) begin
      n2_sx = n2_mx_r >> (n2_pos_r - spte_pkg::POS_W'(30));
      n2_sy = n2_my_r >> (n2_pos_r - spte_pkg::POS_W'(30));
    end else begin
      n2_sx = n2_mx_r << (spte_pkg::POS_W'(30) - n2_pos_r);
      n2_sy = n2_my_r << (spte_pkg::POS_W'(30) - n2_pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n3_v_r <= 1'b0;
    end else begin
      n3_v_r <= n2_v_r;
    end
    n3_side_r <= n2_side_r;
    n3_nx_r   <= n2_sx[30:0];
    n3_ny_r   <= n2_sy[30:0];
  end

  // Stage 4: squares
  logic        n4_v_r;
  side_t       n4_side_r;
  logic [30:0] n4_nx_r, n4_ny_r;
  logic [61:0] n4_qx_r, n4_qy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n4_v_r <= 1'b0;
    end else begin
      n4_v_r <= n3_v_r;
    end
    n4_side_r <= n3_side_r;
    n4_nx_r   <= n3_nx_r;
    n4_ny_r   <= n3_ny_r;
    n4_qx_r   <= 62'(n3_nx_r) * 62'(n3_nx_r);
    n4_qy_r   <= 62'(n3_ny_r) * 62'(n3_ny_r);
  end

  // Square root pipeline, one result bit per stage; entry 0 holds the sum of squares
  logic              sq_v_r    [0:SQ_N];
  side_t             sq_side_r [0:SQ_N];
  logic [30:0]       sq_nx_r   [0:SQ_N];
  logic [30:0]       sq_ny_r   [0:SQ_N];
  logic [63:0]       sq_rem_r  [0:SQ_N];
  logic [63:0]       sq_root_r [0:SQ_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= n4_v_r;
    end
    sq_side_r[0] <= n4_side_r;
    sq_nx_r[0]   <= n4_nx_r;
    sq_ny_r[0]   <= n4_ny_r;
    sq_rem_r[0]  <= 64'(n4_qx_r) + 64'(n4_qy_r);
    sq_root_r[0] <= '0;
  end

  for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * g);
    logic [64:0] trial;

    assign trial = 65'(sq_root_r[g]) + 65'(BIT);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[g+1] <= 1'b0;
      end else begin
        sq_v_r[g+1] <= sq_v_r[g];
      end
      sq_side_r[g+1] <= sq_side_r[g];
      sq_nx_r[g+1]   <= sq_nx_r[g];
      sq_ny_r[g+1]   <= sq_ny_r[g];
      if (65'(sq_rem_r[g]) >= trial) begin
        sq_rem_r[g+1]  <= sq_rem_r[g] - trial[63:0];
        sq_root_r[g+1] <= (sq_root_r[g] >> 1) + BIT;
      end else begin
        sq_rem_r[g+1]  <= sq_rem_r[g];
        sq_root_r[g+1] <= sq_root_r[g] >> 1;
      end
    end
  end

  // Divider pipeline: q = (c * 32768 + len / 2) / len for both components
  logic              dv_v_r    [0:DV_N];
  side_t             dv_side_r [0:DV_N];
  logic [31:0]       dv_den_r  [0:DV_N];
  logic [NUM_W-1:0]  dv_numx_r [0:DV_N];
  logic [NUM_W-1:0]  dv_numy_r [0:DV_N];
  logic [DV_N-1:0]   dv_qx_r   [0:DV_N];
  logic [DV_N-1:0]   dv_qy_r   [0:DV_N];
  logic [31:0]       len;

  assign len = sq_root_r[SQ_N][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[SQ_N];
    end
    dv_side_r[0] <= sq_side_r[SQ_N];
    dv_den_r[0]  <= len;
    dv_numx_r[0] <= (NUM_W'(sq_nx_r[SQ_N]) << 15) + NUM_W'(len >> 1);
    dv_numy_r[0] <= (NUM_W'(sq_ny_r[SQ_N]) << 15) + NUM_W'(len >> 1);
    dv_qx_r[0]   <= '0;
    dv_qy_r[0]   <= '0;
  end

  for (genvar j = 0; j < DV_N; j++) begin : g_div
    localparam int SH = DV_N - 1 - j;
    logic [NUM_W-1:0] dsh;

    assign dsh = NUM_W'(dv_den_r[j]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      dv_side_r[j+1] <= dv_side_r[j];
      dv_den_r[j+1]  <= dv_den_r[j];
      if (dv_numx_r[j] >= dsh) begin
        dv_numx_r[j+1] <= dv_numx_r[j] - dsh;
        dv_qx_r[j+1]   <= dv_qx_r[j] | (DV_N'(1) << SH);
      end else begin
        dv_numx_r[j+1] <= dv_numx_r[j];
        dv_qx_r[j+1]   <= dv_qx_r[j];
      end
      if (dv_numy_r[j] >= dsh) begin
        dv_numy_r[j+1] <= dv_numy_r[j] - dsh;
        dv_qy_r[j+1]   <= dv_qy_r[j] | (DV_N'(1) << SH);
      end else begin
        dv_numy_r[j+1] <= dv_numy_r[j];
        dv_qy_r[j+1]   <= dv_qy_r[j];
      end
    end
  end

  // Output register: apply signs, pass a zero tangent through
  side_t       fin;
  logic [31:0] ux, uy;
  logic        out_valid_r;
  spte_pkg::spte_out_t out_res_r;

  assign fin = dv_side_r[DV_N];
  assign ux  = 32'(dv_qx_r[DV_N]);
  assign uy  = 32'(dv_qy_r[DV_N]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v_r[DV_N];
    end
    out_res_r.pos_x          <= fin.pos_x;
    out_res_r.pos_y          <= fin.pos_y;
    out_res_r.dir_x          <= !fin.nz ? '0 : (fin.neg_x ? -ux : ux);
    out_res_r.dir_y          <= !fin.nz ? '0 : (fin.neg_y ? -uy : uy);
    out_res_r.dir_normalized <= fin.nz;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### hw/rtl/spte_checker.sv
// Port-level checks of the evaluator and their binding to the top level.
module spte_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input spte_pkg::spte_in_t          in_req,
  input logic                        out_valid,
  input spte_pkg::spte_out_t         out_res
);

  logic acc_eval;
  assign acc_eval = start && !busy && (in_req.opcode == spte_pkg::OP_EVAL);

  // every accepted evaluate request yields a result after the fixed latency
  a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc_eval |-> ##(spte_pkg::LATENCY) out_valid)
    else $error("evaluate request lost");

  // no result without an evaluate request accepted at the matching time
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc_eval, spte_pkg::LATENCY))
    else $error("result without request");

  // a zero tangent passes through as zero
  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.dir_normalized) |-> (out_res.dir_x == 0 && out_res.dir_y == 0))
    else $error("unnormalized tangent not zero");

  // a unit tangent component never exceeds 1.0 in Q1.15
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.dir_normalized) |->
      ($signed(out_res.dir_x) <= 32768 && $signed(out_res.dir_x) >= -32768 &&
       $signed(out_res.dir_y) <= 32768 && $signed(out_res.dir_y) >= -32768))
    else $error("tangent component out of range");

endmodule

bind spline_point_and_tangent_eval spte_checker u_spte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

### tb/spte_checker.sv
// Checker for the spline evaluator: predicts each evaluate request and compares results.
`timescale 1ns / 100ps

module spte_scoreboard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  spte_pkg::spte_in_t            in_req,
  input  logic                          out_valid,
  input  spte_pkg::spte_out_t           out_res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [spte_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output int                            fail_count,
  output int                            pending
);

  localparam longint ONE16 = 64'sd1 << 16;
  localparam longint ONE32 = 64'sd1 << 32;
  localparam longint ONE48 = 64'sd1 << 48;
  localparam longint Q28   = 64'sd1 << 28;
  localparam int TABLE_DEPTH = 64;

  // predictor copy of the table and registers
  longint    pt_x [TABLE_DEPTH];
  longint    pt_y [TABLE_DEPTH];
  logic      kind_cr;
  logic [6:0] count_reg;
  spte_pkg::spte_out_t expected_q[$];

  initial pending = 0;

  // num / den rounded half up
  function automatic longint round_div(longint num, longint den);
    longint x;
    x = num + den / 2;
    if (x >= 0) return x / den;
    return -(((-x) + den - 1) / den);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unit_part(longint unsigned a, longint unsigned len, logic neg);
    longint r;
    r = longint'((a * 32768 + len / 2) / len);
    return neg ? -r : r;
  endfunction

  // position and unit tangent at parameter t
  function automatic spte_pkg::spte_out_t curve_sample(logic [16:0] t_in);
    spte_pkg::spte_out_t res;
    longint n, t, segs, scaled, seg, u, u2, u3, v, pd, qd;
    longint p[4], q[4], w[4], d[4];
    longint ax, ay, tx, ty, rx, ry;
    longint unsigned mx, my, m, len;
    int idx[4];
    int k;
    n = count_reg;
    if (n < 4) n = 4;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    t = t_in;
    if (t > 65536) t = 65536;
    segs = kind_cr ? n - 1 : n - 3;
    scaled = t * segs;
    seg = scaled >>> 16;
    if (seg >= segs) seg = segs - 1;
    u = scaled - (seg << 16);
    u2 = u * u;
    u3 = u2 * u;
    if (!kind_cr) begin
      v = ONE16 - u;
      p[0] = v * v * v;
      p[1] = 3 * u3 - 6 * u2 * ONE16 + 4 * ONE48;
      p[2] = -3 * u3 + 3 * u2 * ONE16 + 3 * u * ONE32 + ONE48;
      p[3] = u3;
      q[0] = -(v * v);
      q[1] = 3 * u2 - 4 * u * ONE16;
      q[2] = -3 * u2 + 2 * u * ONE16 + ONE32;
      q[3] = u2;
      pd = 64'sd6 << 20;
      for (k = 0; k < 4; k++) idx[k] = int'(seg) + k;
    end else begin
      p[0] = -u3 + 2 * u2 * ONE16 - u * ONE32;
      p[1] = 3 * u3 - 5 * u2 * ONE16 + 2 * ONE48;
      p[2] = -3 * u3 + 4 * u2 * ONE16 + u * ONE32;
      p[3] = u3 - u2 * ONE16;
      q[0] = -3 * u2 + 4 * u * ONE16 - ONE32;
      q[1] = 9 * u2 - 10 * u * ONE16;
      q[2] = -9 * u2 + 8 * u * ONE16 + ONE32;
      q[3] = 3 * u2 - 2 * u * ONE16;
      pd = 64'sd2 << 20;
      idx[0] = seg > 0 ? int'(seg) - 1 : 0;
      idx[1] = int'(seg);
      idx[2] = int'(seg) + 1;
      idx[3] = (seg + 2 < n) ? int'(seg) + 2 : int'(n) - 1;
    end
    qd = 64'sd2 << 4;
    ax = 0; ay = 0; tx = 0; ty = 0;
    for (k = 0; k < 4; k++) begin
      w[k] = round_div(p[k], pd);
      d[k] = round_div(q[k], qd);
      ax += w[k] * pt_x[idx[k]];
      ay += w[k] * pt_y[idx[k]];
      tx += d[k] * pt_x[idx[k]];
      ty += d[k] * pt_y[idx[k]];
    end
    res.pos_x = 32'(sat_word(round_div(ax, Q28)));
    res.pos_y = 32'(sat_word(round_div(ay, Q28)));
    rx = round_div(tx, Q28);
    ry = round_div(ty, Q28);
    if (rx == 0 && ry == 0) begin
      // zero tangent passes through unnormalized
      res.dir_x = '0;
      res.dir_y = '0;
      res.dir_normalized = 1'b0;
    end else begin
      mx = rx < 0 ? -rx : rx;
      my = ry < 0 ? -ry : ry;
      m = mx > my ? mx : my;
      while (m >= (64'd1 << 31)) begin
        mx = mx >> 1; my = my >> 1; m = m >> 1;
      end
      while (m < (64'd1 << 30)) begin
        mx = mx << 1; my = my << 1; m = m << 1;
      end
      len = floor_sqrt(mx * mx + my * my);
      res.dir_x = 32'(unit_part(mx, len, rx < 0));
      res.dir_y = 32'(unit_part(my, len, ry < 0));
      res.dir_normalized = 1'b1;
    end
    return res;
  endfunction

  task automatic report_field(string name, longint exp_v, longint act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %0d got %0d", name, exp_v, act_v);
  endtask

  // watch the channels; result check uses the queue as it stood before this edge
  always @(posedge clk) begin
    spte_pkg::spte_out_t exp_r;
    if (!rst_n) begin
      kind_cr <= 1'b0;
      count_reg <= 7'd4;
      fail_count = 0;
      expected_q.delete();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        pt_x[i] = 0;
        pt_y[i] = 0;
      end
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result with nothing pending");
        end else begin
          exp_r = expected_q.pop_front();
          if (out_res.pos_x !== exp_r.pos_x) report_field("pos_x", exp_r.pos_x, out_res.pos_x);
          if (out_res.pos_y !== exp_r.pos_y) report_field("pos_y", exp_r.pos_y, out_res.pos_y);
          if (out_res.dir_x !== exp_r.dir_x) report_field("dir_x", exp_r.dir_x, out_res.dir_x);
          if (out_res.dir_y !== exp_r.dir_y) report_field("dir_y", exp_r.dir_y, out_res.dir_y);
          if (out_res.dir_normalized !== exp_r.dir_normalized)
            report_field("dir_normalized", exp_r.dir_normalized, out_res.dir_normalized);
        end
      end
      if (start && !busy) begin
        if (in_req.opcode == spte_pkg::OP_LOAD) begin
          pt_x[in_req.point_index] = longint'(in_req.point_x);
          pt_y[in_req.point_index] = longint'(in_req.point_y);
        end else begin
          expected_q.push_back(curve_sample(in_req.param_t));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (spte_pkg::spte_reg_t'(paddr[2]) == spte_pkg::REG_CURVE_KIND) kind_cr <= pwdata[0];
        else count_reg <= pwdata[6:0];
      end
    end
    pending = expected_q.size();
  end

endmodule

### tb/spline_point_and_tangent_eval_tb.sv
// Testbench top: drives requests and register writes, gives the verdict.
`timescale 1ns / 100ps

module spline_point_and_tangent_eval_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 10;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  spte_pkg::spte_in_t            in_req;
  logic                          out_valid;
  spte_pkg::spte_out_t           out_res;
  logic                          psel, penable, pwrite, pready;
  logic [spte_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                   pwdata, prdata;
  int                            fail_count, pending, cycles;
  logic [63:0]                   loaded;
  int                            burst_left;
  logic                          gaps_on;

  spline_point_and_tangent_eval dut (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  spte_scoreboard checker_i (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_res,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("spline_point_and_tangent_eval verification failed");
      $finish;
    end
  end

  // one request, held until accepted; with gaps on, bursts with random gaps between them
  task automatic send_req(spte_pkg::spte_in_t req);
    logic b;
    start <= 1'b1;
    in_req <= req;
    forever begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
      if (!b) break;
    end
    if (req.opcode == spte_pkg::OP_LOAD) loaded[req.point_index] = 1'b1;
    burst_left--;
    if (gaps_on && burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic load_pt(int slot, logic [31:0] x, logic [31:0] y);
    spte_pkg::spte_in_t r;
    r = '0;
    r.opcode = spte_pkg::OP_LOAD;
    r.point_index = slot[5:0];
    r.point_x = x;
    r.point_y = y;
    send_req(r);
  endtask

  task automatic eval_at(logic [16:0] t);
    spte_pkg::spte_in_t r;
    r.opcode = spte_pkg::OP_EVAL;
    r.point_index = 6'($urandom);
    r.point_x = $urandom;
    r.point_y = $urandom;
    r.param_t = t;
    send_req(r);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 200000)) - 100000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(int'($urandom_range(0, 2000)) - 1000) << 16;
    endcase
  endfunction

  function automatic logic [16:0] rand_t();
    case ($urandom_range(0, 9))
      0: return 17'($urandom_range(65536, 131071));
      1: return $urandom_range(0, 1) ? 17'd0 : 17'd65536;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // quiet the block, then write one register over the config port
  task automatic write_reg(spte_pkg::spte_reg_t idx, logic [31:0] val);
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (spte_pkg::LATENCY + 4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= spte_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // load any slot in use that was never written
  task automatic fill_slots(int cnt);
    int n;
    n = cnt < 4 ? 4 : (cnt > 64 ? 64 : cnt);
    for (int i = 0; i < n; i++)
      if (!loaded[i]) load_pt(i, rand_coord(), rand_coord());
  endtask

  initial begin
    logic [6:0] counts [NUM_PHASES];
    logic       kinds [NUM_PHASES];
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    loaded = '0;
    burst_left = 5;
    gaps_on = 1'b0;
    counts = '{7'd4, 7'd4, 7'd64, 7'd64, 7'd2, 7'd100, 7'd5, 7'd17, 7'd127, 7'd30};
    kinds = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    counts[9] = 7'($urandom_range(4, 64));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: equal points give a zero tangent
    for (int i = 0; i < 4; i++) load_pt(i, 32'h0012_3400, 32'hFFF0_0000);
    eval_at(17'd0);
    eval_at(17'd32768);
    // extreme coordinates and t at both ends and beyond 1.0
    load_pt(0, 32'h8000_0000, 32'h7FFF_FFFF);
    load_pt(1, 32'h7FFF_FFFF, 32'h8000_0000);
    load_pt(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    load_pt(3, 32'h8000_0000, 32'h8000_0000);
    eval_at(17'd0);
    eval_at(17'd65535);
    eval_at(17'd65536);
    eval_at(17'd131071);
    eval_at(17'd21845);
    write_reg(spte_pkg::REG_CURVE_KIND, 32'd1);
    eval_at(17'd32768);
    eval_at(17'd0);
    eval_at(17'd65536);
    eval_at(17'd43690);
    eval_at(17'd1);

    // random phases across curve kinds and point counts
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(spte_pkg::REG_CURVE_KIND, {31'd0, kinds[ph]});
      write_reg(spte_pkg::REG_POINT_COUNT, {25'd0, counts[ph]});
      gaps_on = (ph % 3) != 1;
      fill_slots(counts[ph] == 7'd127 ? 64 : counts[ph]);
      for (int i = 0; i < 165; i++) begin
        if ($urandom_range(0, 3) == 0) load_pt($urandom_range(0, 63), rand_coord(), rand_coord());
        else eval_at(rand_t());
      end
    end

    start <= 1'b0;
    wait (pending == 0);
    repeat (spte_pkg::LATENCY + 8) @(posedge clk);
    if (fail_count == 0) $display("spline_point_and_tangent_eval verification clean");
    else $display("spline_point_and_tangent_eval verification failed");
    $finish;
  end

endmodule

### files.f
hw/rtl/spte_pkg.sv
hw/rtl/spte_norm.sv
hw/rtl/spline_point_and_tangent_eval.sv
hw/rtl/spte_checker.sv
tb/spte_checker.sv
tb/spline_point_and_tangent_eval_tb.sv
